FILE: rtl/core/svk_pkg.sv
// Shared types, codes and saturating arithmetic for the two-row SYMV panel kernel.
package svk_pkg;

  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 2 * DATA_W;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // Column kinds; the unused code behaves as a full column.
  typedef enum logic [1:0] {
    KIND_FULL = 2'd0,
    KIND_DIAG = 2'd1,
    KIND_TAIL = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_T_FIRST       = 3'd0,
    CFG_X_T_SECOND      = 3'd1,
    CFG_Y_N_INIT_FIRST  = 3'd2,
    CFG_Y_N_INIT_SECOND = 3'd3,
    CFG_SUBTRACT_MODE   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    kind_t kind;
    logic  last;
  } col_ctl_t;

  // acc +/- p, saturated to the signed data range
  function automatic data_t sat_upd(data_t acc, wide_t p, logic sub);
    logic signed [WIDE_W:0] a_x;
    logic signed [WIDE_W:0] p_x;
    logic signed [WIDE_W:0] s;
    logic [WIDE_W-DATA_W+1:0] top;
    a_x = {{(WIDE_W+1-DATA_W){acc[DATA_W-1]}}, acc};
    p_x = {p[WIDE_W-1], p};
    s   = sub ? (a_x - p_x) : (a_x + p_x);
    top = s[WIDE_W:DATA_W-1];
    if ((top == '0) || (top == '1)) begin
      return s[DATA_W-1:0];
    end else if (s[WIDE_W]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  function automatic wide_t sext_wide(data_t v);
    return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

FILE: rtl/core/svk_prod.sv
// Product stage: four Q-format products, floor-shifted and registered.
module svk_prod
  import svk_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  en,
  input  data_t a_row0,
  input  data_t a_row1,
  input  data_t x_n_elem,
  input  data_t x_t_first,
  input  data_t x_t_second,
  output wide_t pn0,
  output wide_t pn1,
  output wide_t pt0,
  output wide_t pt1
);

  wide_t mn0, mn1, mt0, mt1;
  wide_t pn0_r, pn1_r, pt0_r, pt1_r;

  assign mn0 = sext_wide(a_row0) * sext_wide(x_n_elem);
  assign mn1 = sext_wide(a_row1) * sext_wide(x_n_elem);
  assign mt0 = sext_wide(a_row0) * sext_wide(x_t_first);
  assign mt1 = sext_wide(a_row1) * sext_wide(x_t_second);

  // arithmetic shift gives the floor rounding
  always_ff @(posedge clk) begin
    if (en) begin
      pn0_r <= mn0 >>> FRAC_BITS;
      pn1_r <= mn1 >>> FRAC_BITS;
      pt0_r <= mt0 >>> FRAC_BITS;
      pt1_r <= mt1 >>> FRAC_BITS;
    end
  end

  assign pn0 = pn0_r;
  assign pn1 = pn1_r;
  assign pt0 = pt0_r;
  assign pt1 = pt1_r;

endmodule

FILE: rtl/core/svk_acc.sv
// Accumulate stage: row accumulators plus the row-zero term of the transposed update.
module svk_acc
  import svk_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     sub,
  input  wide_t    pn0,
  input  wide_t    pn1,
  input  wide_t    pt0,
  input  wide_t    pt1,
  input  data_t    y_t_elem,
  input  col_ctl_t ctl,
  output data_t    yt_part,
  output wide_t    pt1_out,
  output data_t    sum0,
  output data_t    sum1,
  output col_ctl_t ctl_out
);

  data_t    acc0_r, acc1_r;
  data_t    acc0_nxt, acc1_nxt;
  data_t    new0, new1, yt_nxt;
  data_t    yt_part_r, sum0_r, sum1_r;
  wide_t    pt1_r;
  col_ctl_t ctl_r;

  always_comb begin
    new0   = (ctl.kind == KIND_TAIL) ? acc0_r : sat_upd(acc0_r, pn0, sub);
    new1   = sat_upd(acc1_r, pn1, sub);
    // diagonal and tail columns leave out the row-zero term
    yt_nxt = ((ctl.kind == KIND_DIAG) || (ctl.kind == KIND_TAIL)) ?
             y_t_elem : sat_upd(y_t_elem, pt0, sub);
    acc0_nxt = ctl.last ? '0 : new0;
    acc1_nxt = ctl.last ? '0 : new1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc0_r <= '0;
      acc1_r <= '0;
    end else if (en) begin
      acc0_r <= acc0_nxt;
      acc1_r <= acc1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yt_part_r <= yt_nxt;
      pt1_r     <= pt1;
      sum0_r    <= new0;
      sum1_r    <= new1;
      ctl_r     <= ctl;
    end
  end

  assign yt_part = yt_part_r;
  assign pt1_out = pt1_r;
  assign sum0    = sum0_r;
  assign sum1    = sum1_r;
  assign ctl_out = ctl_r;

endmodule

FILE: rtl/core/svk_out.sv
// Result stage: row-one transposed term and the final normal sums.
module svk_out
  import svk_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  logic     sub,
  input  data_t    y_n_init_first,
  input  data_t    y_n_init_second,
  input  data_t    yt_part,
  input  wide_t    pt1,
  input  data_t    sum0,
  input  data_t    sum1,
  input  col_ctl_t ctl,
  output data_t    y_t_out,
  output logic     y_t_valid,
  output data_t    y_n_out_first,
  output data_t    y_n_out_second,
  output logic     done_res
);

  data_t yt_r, yn0_r, yn1_r;
  logic  ytv_r, done_r;
  logic  tail;

  assign tail = (ctl.kind == KIND_TAIL);

  always_ff @(posedge clk) begin
    if (en) begin
      yt_r   <= tail ? '0 : sat_upd(yt_part, pt1, sub);
      ytv_r  <= !tail;
      yn0_r  <= ctl.last ? sat_upd(y_n_init_first, sext_wide(sum0), 1'b0) : '0;
      yn1_r  <= ctl.last ? sat_upd(y_n_init_second, sext_wide(sum1), 1'b0) : '0;
      done_r <= ctl.last;
    end
  end

  assign y_t_out        = yt_r;
  assign y_t_valid      = ytv_r;
  assign y_n_out_first  = yn0_r;
  assign y_n_out_second = yn1_r;
  assign done_res       = done_r;

endmodule

FILE: rtl/core/two_row_symv_panel_kernel_top.sv
// Top level of the two-row SYMV panel kernel: handshakes, config registers, pipeline.
// Path: a beat accepted into the input reg moves through the stage registers in order
// (input reg -> product reg -> accumulate reg -> result reg).
// Throughput: one column per cycle; every stage advances when the one after it
// is empty or draining, so the pipeline only stalls on out_ready.
// Reset (rst_n, synchronous, active low) clears stage valid flags, both row
// accumulators and all config registers; payload registers are not reset.
module two_row_symv_panel_kernel_top
  import svk_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_a_row0,
  input  logic signed [31:0]   in_a_row1,
  input  logic signed [31:0]   in_x_n_elem,
  input  logic signed [31:0]   in_y_t_elem,
  input  logic [1:0]           in_column_kind,
  input  logic                 in_last,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_y_t_out,
  output logic                 out_y_t_valid,
  output logic signed [31:0]   out_y_n_out_first,
  output logic signed [31:0]   out_y_n_out_second,
  output logic                 out_done_res
);

  // ---------------------------------------------------------------
  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  // ---------------------------------------------------------------
  data_t x_t_first_r, x_t_second_r, y_n_init_first_r, y_n_init_second_r;
  logic  subtract_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_t_first_r       <= '0;
      x_t_second_r      <= '0;
      y_n_init_first_r  <= '0;
      y_n_init_second_r <= '0;
      subtract_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_T_FIRST:       x_t_first_r       <= cfg_wdata;
        CFG_X_T_SECOND:      x_t_second_r      <= cfg_wdata;
        CFG_Y_N_INIT_FIRST:  y_n_init_first_r  <= cfg_wdata;
        CFG_Y_N_INIT_SECOND: y_n_init_second_r <= cfg_wdata;
        CFG_SUBTRACT_MODE:   subtract_mode_r   <= cfg_wdata[0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Stage occupancy. Stage 1 = input reg, 2 = products,
  // 3 = accumulate, 4 = result reg (drives out_*).
  // A stage loads when it is empty or the next one is loading.
  // ---------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign ld1 = in_valid && rdy1;
  assign ld2 = v1_r && rdy2;
  assign ld3 = v2_r && rdy3;   // accumulators step exactly once per beat here
  assign ld4 = v3_r && rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign in_ready  = rdy1;
  assign out_valid = v4_r;

  // ---------------------------------------------------------------
  // Input register and the control that rides along with the data.
  // ---------------------------------------------------------------
  data_t    s1_a0_r, s1_a1_r, s1_xn_r, s1_yt_r;
  col_ctl_t s1_ctl_r, s2_ctl_r;
  data_t    s2_yt_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_a0_r       <= in_a_row0;
      s1_a1_r       <= in_a_row1;
      s1_xn_r       <= in_x_n_elem;
      s1_yt_r       <= in_y_t_elem;
      s1_ctl_r.kind <= kind_t'(in_column_kind);
      s1_ctl_r.last <= in_last;
    end
    if (ld2) begin
      s2_yt_r  <= s1_yt_r;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // Stage 2: the four 32x32 products, one multiplier each
  wide_t pn0, pn1, pt0, pt1;

  svk_prod #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prod (
    .clk        (clk),
    .en         (ld2),
    .a_row0     (s1_a0_r),
    .a_row1     (s1_a1_r),
    .x_n_elem   (s1_xn_r),
    .x_t_first  (x_t_first_r),
    .x_t_second (x_t_second_r),
    .pn0        (pn0),
    .pn1        (pn1),
    .pt0        (pt0),
    .pt1        (pt1)
  );

  // Stage 3: accumulators (cleared on the last column) and first y_t term
  data_t    yt_part, sum0, sum1;
  wide_t    s3_pt1;
  col_ctl_t s3_ctl;

  svk_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (ld3),
    .sub      (subtract_mode_r),
    .pn0      (pn0),
    .pn1      (pn1),
    .pt0      (pt0),
    .pt1      (pt1),
    .y_t_elem (s2_yt_r),
    .ctl      (s2_ctl_r),
    .yt_part  (yt_part),
    .pt1_out  (s3_pt1),
    .sum0     (sum0),
    .sum1     (sum1),
    .ctl_out  (s3_ctl)
  );

  // Stage 4: result register
  svk_out u_out (
    .clk             (clk),
    .en              (ld4),
    .sub             (subtract_mode_r),
    .y_n_init_first  (y_n_init_first_r),
    .y_n_init_second (y_n_init_second_r),
    .yt_part         (yt_part),
    .pt1             (s3_pt1),
    .sum0            (sum0),
    .sum1            (sum1),
    .ctl             (s3_ctl),
    .y_t_out         (out_y_t_out),
    .y_t_valid       (out_y_t_valid),
    .y_n_out_first   (out_y_n_out_first),
    .y_n_out_second  (out_y_n_out_second),
    .done_res        (out_done_res)
  );

`ifndef SYNTHESIS
  // Backpressure only reaches the input once every stage holds a beat.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && v4_r))
    else $error("in_ready low with an empty stage");

  // Normal results read zero except on the panel's last column.
  a_yn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_y_n_out_first == '0 && out_y_n_out_second == '0))
    else $error("normal result nonzero on a non-last beat");

  // A tail column leaves the transposed element unwritten and zero.
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_y_t_valid) |-> (out_y_t_out == '0))
    else $error("tail beat carries a nonzero y_t");

  // A beat entering the accumulate stage shows on the output one load later.
  a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !v4_r) |=> v4_r)
    else $error("result register failed to take a waiting beat");
`endif

endmodule
